// ===== rtl/srt_pkg.sv =====
// shared constants, types and helper functions of the sorted record table
package srt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int SCORE_W     = 8;
	localparam int POS_W       = 4;
	localparam int MAX_RESULTS = 16;
	localparam int N_W         = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_NO_MATCH  = 2'd3
	} status_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
	} entry_t;

	// one result word handed from the sequencer to the output register
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
		logic [POS_W-1:0]   pos;
		logic               last;
		status_t            status;
	} res_t;

	// record a ranks before record b: higher score, then smaller key
	function automatic logic ranks_before(input logic [KEY_W-1:0] ka,
		input logic [SCORE_W-1:0] sa, input logic [KEY_W-1:0] kb,
		input logic [SCORE_W-1:0] sb);
		return (sa != sb) ? (sa > sb) : (ka < kb);
	endfunction

	// low bits of a slot number as reported on the result port
	function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/srt_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/srt_ctrl.sv =====
// command sequencer: scans the table memory, shifts entries and builds results
module srt_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   command,
	input  logic [srt_pkg::KEY_W-1:0]    key_id,
	input  logic [srt_pkg::SCORE_W-1:0]  score_value,
	output logic                         res_valid,
	output srt_pkg::res_t                res,
	input  logic                         res_ready,
	output logic                         mem_we,
	output logic [srt_pkg::IDX_W-1:0]    mem_waddr,
	output srt_pkg::entry_t              mem_wdata,
	output logic [srt_pkg::IDX_W-1:0]    mem_raddr,
	input  srt_pkg::entry_t              mem_rdata
);

	import srt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_START     = 8'b0000_0010,
		S_DEL       = 8'b0000_0100,
		S_INS_START = 8'b0000_1000,
		S_INS       = 8'b0001_0000,
		S_PLACE     = 8'b0010_0000,
		S_LST       = 8'b0100_0000,
		S_FIN       = 8'b1000_0000
	} state_t;

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [SCORE_W-1:0]  score_q;
	logic [IDX_W-1:0]    idx_s1, idx_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    cnt_m1;
	logic                found_q, found_d;
	logic [IDX_W-1:0]    p_q, p_d;
	res_t                pend_q, pend_d;
	logic                pend_v_q, pend_v_d;
	logic [N_W-1:0]      n_q, n_d;
	logic                last_idx;
	logic                key_hit;
	logic                score_hit;
	logic                stall;

	assign in_ready  = (state_q == S_IDLE);
	assign mem_raddr = idx_d;
	assign cnt_m1    = count_q - CNT_W'(1);
	assign last_idx  = (CNT_W'(idx_s1) == cnt_m1);
	assign key_hit   = (mem_rdata.key == key_q);
	assign score_hit = (mem_rdata.score > score_q);
	assign stall     = score_hit && pend_v_q && !res_ready;

	// next-state and memory access logic
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_s1;
		count_d   = count_q;
		found_d   = found_q;
		p_d       = p_q;
		pend_d    = pend_q;
		pend_v_d  = pend_v_q;
		n_d       = n_q;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		res_valid = 1'b0;
		res       = pend_q;
		res.last  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				unique case (cmd_q) inside
					CMD_INSERT: begin
						state_d = S_INS_START;
					end
					CMD_DELETE, CMD_UPDATE: begin
						found_d = 1'b0;
						if (count_q == '0) begin
							pend_d  = '{key: key_q, score: '0, pos: '0, last: 1'b0,
								status: ST_NOT_FOUND};
							state_d = S_FIN;
						end else begin
							idx_d   = '0;
							state_d = S_DEL;
						end
					end
					default: begin
						pend_v_d = 1'b0;
						n_d      = '0;
						if (count_q == '0) begin
							pend_d  = '{key: '0, score: '0, pos: '0, last: 1'b0,
								status: ST_NO_MATCH};
							state_d = S_FIN;
						end else begin
							idx_d   = '0;
							state_d = S_LST;
						end
					end
				endcase
			end
			// forward search for the key, then pull later entries up by one
			S_DEL: begin
				idx_d = idx_s1 + 1'b1;
				if (found_q) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 - 1'b1;
				end else if (key_hit) begin
					found_d = 1'b1;
					pend_d  = '{key: mem_rdata.key, score: mem_rdata.score,
						pos: to_pos(idx_s1), last: 1'b0, status: ST_OK};
				end
				if (last_idx) begin
					if (found_q || key_hit) begin
						count_d = cnt_m1;
						state_d = (cmd_q == CMD_UPDATE) ? S_INS_START : S_FIN;
					end else begin
						pend_d  = '{key: key_q, score: '0, pos: '0, last: 1'b0,
							status: ST_NOT_FOUND};
						state_d = S_FIN;
					end
				end
			end
			S_INS_START: begin
				if (count_q == CNT_W'(TABLE_DEPTH)) begin
					pend_d  = '{key: key_q, score: score_q, pos: '0, last: 1'b0,
						status: ST_FULL};
					state_d = S_FIN;
				end else if (count_q == '0) begin
					p_d     = '0;
					state_d = S_PLACE;
				end else begin
					idx_d   = cnt_m1[IDX_W-1:0];
					state_d = S_INS;
				end
			end
			// backward walk, pushing lower-ranked entries down by one
			S_INS: begin
				if (ranks_before(key_q, score_q, mem_rdata.key, mem_rdata.score)) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 + 1'b1;
					if (idx_s1 == '0) begin
						p_d     = '0;
						state_d = S_PLACE;
					end else begin
						idx_d = idx_s1 - 1'b1;
					end
				end else begin
					p_d     = idx_s1 + 1'b1;
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = p_q;
				mem_wdata = '{key: key_q, score: score_q};
				count_d   = count_q + CNT_W'(1);
				pend_d    = '{key: key_q, score: score_q, pos: to_pos(p_q), last: 1'b0,
					status: ST_OK};
				state_d   = S_FIN;
			end
			// list scan: each new match releases the one held before it
			S_LST: begin
				if (score_hit && pend_v_q) begin
					res_valid = 1'b1;
				end
				if (!stall) begin
					idx_d = idx_s1 + 1'b1;
					if (score_hit) begin
						pend_d   = '{key: mem_rdata.key, score: mem_rdata.score,
							pos: to_pos(idx_s1), last: 1'b0, status: ST_OK};
						pend_v_d = 1'b1;
						n_d      = n_q + 1'b1;
					end
					if (last_idx || (score_hit && n_q == N_W'(MAX_RESULTS - 1))) begin
						if (!(score_hit || pend_v_q)) begin
							pend_d = '{key: '0, score: '0, pos: '0, last: 1'b0,
								status: ST_NO_MATCH};
						end
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				res_valid = 1'b1;
				res.last  = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			n_q      <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			found_q  <= found_d;
			pend_v_q <= pend_v_d;
			n_q      <= n_d;
		end
	end

	// command word, scan index and pending result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q   <= cmd_t'(command);
			key_q   <= key_id;
			score_q <= score_value;
		end
		idx_s1 <= idx_d;
		p_q    <= p_d;
		pend_q <= pend_d;
	end

endmodule

// ===== rtl/sorted_record_table_unit.sv =====
// Sorted record table: a table of (key, score) records kept in rank order.
// Input words (command, key_id, score_value) arrive on in_valid/in_ready,
// result words leave on out_valid/out_ready, each on its own port.
// Commands: insert, delete by key, update score, list above a threshold.
// Insert, delete and update give one word with last set; list gives one word
// per matching record in table order (at most 16) with last on the final one,
// or a single no-match word.
// The records live in one memory with a registered read; each command walks it
// one entry per cycle, reading one entry and writing the shifted one back in the
// same cycle, except while a stalled receiver holds the list scan.
// An update makes two walks over the memory, one to take the record out and
// one to put it back in rank order; every word may also wait on out_ready.
// in_ready is high only while the sequencer is idle; the output register
// lets the next command start while the previous result word waits.
// A stalled receiver holds the list scan in place until the word is taken.
// Reset empties the table at once; no clearing pass is needed.
module sorted_record_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] key_id,
	input  logic [7:0]  score_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] rec_key,
	output logic [7:0]  rec_score,
	output logic [3:0]  rec_position,
	output logic        last,
	output logic [1:0]  status
);

	import srt_pkg::*;

	logic               res_valid;
	res_t               res;
	logic               res_ready;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;
	logic [IDX_W-1:0]   mem_raddr;
	entry_t             mem_rdata;
	logic               out_valid_q;
	res_t               out_q;

	srt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.key_id      (key_id),
		.score_value (score_value),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	srt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign rec_key      = out_q.key;
	assign rec_score    = out_q.score;
	assign rec_position = out_q.pos;
	assign last         = out_q.last;
	assign status       = out_q.status;

	// error and no-match words always close their command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last)
		else $error("error status word without last");

	// an idle sequencer neither emits nor writes the table
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid && !mem_we)
		else $error("activity while idle");

	// an accepted command takes the sequencer out of idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("still ready after accepting a word");

endmodule

// ===== tb/sorted_record_table_unit_test.sv =====
// testbench of the sorted record table: directed table, random phases, score-order predictor
`timescale 1ns / 1ps

module sorted_record_table_unit_test;
	import srt_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 500;
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASE_ITEMS = 33;

	// one expected result word
	typedef struct {
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
		logic [POS_W-1:0]   pos;
		logic               last;
		status_t            status;
	} rec_word_t;

	// one row of the directed table
	typedef struct {
		cmd_t               cmd;
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
		bit                 typed;
		rec_word_t          want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = 2'd0;
	logic [31:0] key_id = 32'd0;
	logic [7:0]  score_value = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] rec_key;
	logic [7:0]  rec_score;
	logic [3:0]  rec_position;
	logic        last;
	logic [1:0]  status;

	// predicted table contents, in rank order
	logic [KEY_W-1:0]   tbl_key [TABLE_DEPTH];
	logic [SCORE_W-1:0] tbl_score [TABLE_DEPTH];
	int                 held = 0;

	rec_word_t pending_words[$];
	stim_row_t dir_rows[$];
	rec_word_t blank_word;

	int fails = 0;
	int cycle_count = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_trig = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	sorted_record_table_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.key_id      (key_id),
		.score_value (score_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rec_key     (rec_key),
		.rec_score   (rec_score),
		.rec_position(rec_position),
		.last        (last),
		.status      (status)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic rec_word_t make_word(logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s,
		int p, bit l, status_t st);
		rec_word_t w;
		w.key = k;
		w.score = s;
		w.pos = POS_W'(p);
		w.last = l;
		w.status = st;
		return w;
	endfunction

	// higher score first, then smaller key
	function automatic bit ranks_ahead(logic [KEY_W-1:0] ka, logic [SCORE_W-1:0] sa,
		logic [KEY_W-1:0] kb, logic [SCORE_W-1:0] sb);
		if (sa != sb)
			return sa > sb;
		return ka < kb;
	endfunction

	// a new record goes after every entry it does not outrank
	function automatic int insert_record(logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s);
		int p;
		p = 0;
		while (p < held && !ranks_ahead(k, s, tbl_key[p], tbl_score[p]))
			p++;
		for (int x = held; x > p; x--) begin
			tbl_key[x] = tbl_key[x-1];
			tbl_score[x] = tbl_score[x-1];
		end
		tbl_key[p] = k;
		tbl_score[p] = s;
		held++;
		return p;
	endfunction

	// first slot holding the key, or held when absent
	function automatic int find_record(logic [KEY_W-1:0] k);
		int i;
		i = 0;
		while (i < held && tbl_key[i] != k)
			i++;
		return i;
	endfunction

	function automatic void remove_record(int p);
		for (int x = p; x + 1 < held; x++) begin
			tbl_key[x] = tbl_key[x+1];
			tbl_score[x] = tbl_score[x+1];
		end
		held--;
	endfunction

	// apply one command to the predicted table and queue its result words
	function automatic void predict_word(cmd_t cmd, logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s);
		int p;
		int n;
		case (cmd)
			CMD_INSERT: begin
				if (held >= TABLE_DEPTH) begin
					pending_words.push_back(make_word(k, s, 0, 1'b1, ST_FULL));
				end else begin
					p = insert_record(k, s);
					pending_words.push_back(make_word(k, s, p, 1'b1, ST_OK));
				end
			end
			CMD_DELETE: begin
				p = find_record(k);
				if (p >= held) begin
					pending_words.push_back(make_word(k, 8'd0, 0, 1'b1, ST_NOT_FOUND));
				end else begin
					pending_words.push_back(make_word(tbl_key[p], tbl_score[p], p, 1'b1, ST_OK));
					remove_record(p);
				end
			end
			CMD_UPDATE: begin
				p = find_record(k);
				if (p >= held) begin
					pending_words.push_back(make_word(k, 8'd0, 0, 1'b1, ST_NOT_FOUND));
				end else begin
					remove_record(p);
					p = insert_record(k, s);
					pending_words.push_back(make_word(k, s, p, 1'b1, ST_OK));
				end
			end
			default: begin
				n = 0;
				for (int i = 0; i < held && n < MAX_RESULTS; i++) begin
					if (tbl_score[i] > s) begin
						pending_words.push_back(make_word(tbl_key[i], tbl_score[i], i, 1'b0, ST_OK));
						n++;
					end
				end
				if (n == 0)
					pending_words.push_back(make_word(32'd0, 8'd0, 0, 1'b1, ST_NO_MATCH));
				else
					pending_words[pending_words.size()-1].last = 1'b1;
			end
		endcase
	endfunction

	// offer one word, with random idle cycles ahead of it, and predict on acceptance
	task automatic send_word(cmd_t cmd, logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s,
		bit typed, rec_word_t want);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		key_id <= k;
		score_value <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_word(cmd, k, s);
		// typed rows give one word whose value is known up front
		if (typed) begin
			void'(pending_words.pop_back());
			pending_words.push_back(want);
		end
	endtask

	// stop offering and wait until every expected word has arrived
	task automatic drain_words();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(cmd_t cmd, logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s,
		bit typed, rec_word_t want);
		stim_row_t r;
		r.cmd = cmd;
		r.key = k;
		r.score = s;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endtask

	// keys mostly from the table, so deletes and updates usually hit
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 60 && held > 0)
			return tbl_key[$urandom_range(held - 1)];
		if (r < 80)
			return KEY_W'($urandom_range(15));
		return $urandom;
	endfunction

	// a few common scores make ties frequent
	function automatic logic [SCORE_W-1:0] pick_score();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 8'd0;
		if (r < 20)
			return 8'hff;
		if (r < 45)
			return SCORE_W'(10 * $urandom_range(1, 3));
		return SCORE_W'($urandom_range(255));
	endfunction

	task automatic run_random(int count);
		int r;
		cmd_t cmd;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 40)
				cmd = CMD_INSERT;
			else if (r < 60)
				cmd = CMD_DELETE;
			else if (r < 78)
				cmd = CMD_UPDATE;
			else
				cmd = CMD_LIST;
			send_word(cmd, pick_key(), pick_score(), 1'b0, blank_word);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fails++;
		end
	endfunction

	// receiver: compare each taken word, then choose out_ready for the next cycle
	always @(posedge clk) begin
		rec_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word: rec_key %0h status %0d", rec_key, status);
				fails++;
			end else begin
				want = pending_words.pop_front();
				check_field("rec_key", want.key, rec_key);
				check_field("rec_score", 32'(want.score), 32'(rec_score));
				check_field("rec_position", 32'(want.pos), 32'(rec_position));
				check_field("last", 32'(want.last), 32'(last));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
		if (hold_trig != hold_seen) begin
			hold_seen = hold_trig;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		blank_word = make_word(32'd0, 8'd0, 0, 1'b0, ST_OK);

		// empty table errors, extremes, exact duplicate and tie on score
		add_row(CMD_LIST, 32'd0, 8'd0, 1'b1, make_word(32'd0, 8'd0, 0, 1'b1, ST_NO_MATCH));
		add_row(CMD_DELETE, 32'd5, 8'd77, 1'b1, make_word(32'd5, 8'd0, 0, 1'b1, ST_NOT_FOUND));
		add_row(CMD_UPDATE, 32'd7, 8'd9, 1'b1, make_word(32'd7, 8'd0, 0, 1'b1, ST_NOT_FOUND));
		add_row(CMD_INSERT, 32'hffff_ffff, 8'd0, 1'b1,
			make_word(32'hffff_ffff, 8'd0, 0, 1'b1, ST_OK));
		add_row(CMD_INSERT, 32'd0, 8'hff, 1'b1, make_word(32'd0, 8'hff, 0, 1'b1, ST_OK));
		add_row(CMD_INSERT, 32'd0, 8'hff, 1'b0, blank_word);
		add_row(CMD_INSERT, 32'd100, 8'd128, 1'b0, blank_word);
		add_row(CMD_INSERT, 32'd50, 8'd128, 1'b0, blank_word);
		// fill the table
		for (int i = 0; i < TABLE_DEPTH - 5; i++)
			add_row(CMD_INSERT, 32'h0000_1000 + 32'(i) * 32'h1111, 8'((i * 53 + 7) % 256),
				1'b0, blank_word);
		add_row(CMD_INSERT, 32'd9, 8'd9, 1'b1, make_word(32'd9, 8'd9, 0, 1'b1, ST_FULL));
		add_row(CMD_DELETE, 32'hffff_ffff, 8'd0, 1'b0, blank_word);
		add_row(CMD_INSERT, 32'h1234_5678, 8'd1, 1'b0, blank_word);
		// every record above zero: a full-length list
		add_row(CMD_LIST, 32'hdead_beef, 8'd0, 1'b0, blank_word);
		add_row(CMD_LIST, 32'd0, 8'hff, 1'b1, make_word(32'd0, 8'd0, 0, 1'b1, ST_NO_MATCH));
		// duplicate keys: the first one moves, then the other goes
		add_row(CMD_UPDATE, 32'd0, 8'd1, 1'b0, blank_word);
		add_row(CMD_DELETE, 32'd0, 8'd0, 1'b0, blank_word);
		add_row(CMD_UPDATE, 32'd50, 8'hff, 1'b0, blank_word);

		// reset
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i])
			send_word(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].score,
				dir_rows[i].typed, dir_rows[i].want);
		drain_words();

		// no idling, with a long receiver hold-off at the start
		hold_trig <= ~hold_trig;
		run_random(PHASE_ITEMS);
		drain_words();

		// sender mostly idle
		send_idle = 86;
		run_random(PHASE_ITEMS);
		drain_words();

		// receiver mostly stalling
		send_idle = 0;
		recv_stall <= 86;
		run_random(PHASE_ITEMS);
		drain_words();

		// both idling
		send_idle = 33;
		recv_stall <= 33;
		run_random(PHASE_ITEMS);
		drain_words();

		if (fails == 0 && pending_words.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
